@@ src/tcw_pkg.sv @@
// tcw_pkg: shared types and constants for the text console writer
// no dependencies; imported by every module of the block except tcw_ram
package tcw_pkg;

	localparam int CELL_IDX_W = 11;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] RESET_ATTR   = 8'h0F;

	// register word index, taken from paddr[2]
	localparam logic [0:0] REG_TEXT_ATTR = 1'b0;

	typedef enum logic [2:0] {
		OP_PUT_CHAR  = 3'd0,
		OP_NEWLINE   = 3'd1,
		OP_BACKSPACE = 3'd2,
		OP_CLEAR     = 3'd3,
		OP_SET_CUR   = 3'd4,
		OP_READ_CELL = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]            op;
		logic [7:0]            char_code;
		logic [CELL_IDX_W-1:0] cell_index;
	} in_item_t;

	typedef struct packed {
		logic [CELL_IDX_W-1:0] cursor_cell;
		logic [7:0]            cell_char;
		logic [7:0]            cell_attr;
		logic                  scrolled;
	} out_item_t;

	typedef enum logic [1:0] {
		SWP_INIT,
		SWP_SCROLL,
		SWP_CLEAR
	} sweep_mode_t;

	typedef enum logic [3:0] {
		CUR_HOLD,
		CUR_SCROLL_BACK,
		CUR_NEWLINE,
		CUR_PUT,
		CUR_BACK,
		CUR_ZERO,
		CUR_LOAD,
		CUR_DIV_STEP,
		CUR_DIV_END
	} cursor_op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_PUT,
		ST_BS2,
		ST_DIV,
		ST_DONE
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic        capture;
		logic        sweep_start;
		logic        sweep_step;
		sweep_mode_t sweep_mode;
		cursor_op_t  cur_op;
		logic        blank_next;
		logic        rd_cell;
		logic        load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       past_end;
		logic       nl_scroll;
		logic       sweep_done;
		logic       rem_ge_cols;
		logic       out_free;
	} dp_stat_t;

endpackage

@@ src/tcw_ram.sv @@
// tcw_ram: generic single write port, single read port ram with registered read
// no dependencies
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/tcw_ctrl.sv @@
// tcw_ctrl: sequencing state machine of the text console writer
// depends on tcw_pkg; drives the datapath through ctl_cmd_t
module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q, state_d;
	logic       take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// new transaction can enter when idle, or when the finished result leaves
	assign item_stall = !((state_q == ST_IDLE) || ((state_q == ST_DONE) && stat.out_free));
	assign take       = item_valid && !item_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (stat.sweep_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (take) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (stat.op)
					OP_PUT_CHAR:  state_d = stat.past_end ? ST_SWEEP : ST_DONE;
					OP_NEWLINE:   state_d = stat.nl_scroll ? ST_SWEEP : ST_DONE;
					OP_BACKSPACE: state_d = ST_BS2;
					OP_CLEAR:     state_d = ST_SWEEP;
					OP_SET_CUR:   state_d = ST_DIV;
					default:      state_d = ST_DONE;
				endcase
			end
			ST_SWEEP: begin
				if (stat.sweep_done) begin
					state_d = (stat.op == OP_PUT_CHAR) ? ST_PUT : ST_DONE;
				end
			end
			ST_PUT:  state_d = ST_DONE;
			ST_BS2:  state_d = ST_DONE;
			ST_DIV: begin
				if (!stat.rem_ge_cols) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) state_d = take ? ST_EXEC : ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// commands
	always_comb begin
		cmd            = '0;
		cmd.sweep_mode = SWP_SCROLL;
		cmd.cur_op     = CUR_HOLD;
		cmd.capture    = take;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep_step = 1'b1;
			end
			ST_IDLE: ;
			ST_EXEC: begin
				case (stat.op)
					OP_PUT_CHAR: begin
						if (stat.past_end) begin
							cmd.cur_op      = CUR_SCROLL_BACK;
							cmd.sweep_start = 1'b1;
						end else begin
							cmd.cur_op = CUR_PUT;
						end
					end
					OP_NEWLINE: begin
						cmd.cur_op      = CUR_NEWLINE;
						cmd.sweep_start = stat.nl_scroll;
					end
					OP_BACKSPACE: cmd.cur_op = CUR_BACK;
					OP_CLEAR: begin
						cmd.cur_op      = CUR_ZERO;
						cmd.sweep_start = 1'b1;
						cmd.sweep_mode  = SWP_CLEAR;
					end
					OP_SET_CUR:   cmd.cur_op = CUR_LOAD;
					OP_READ_CELL: cmd.rd_cell = 1'b1;
					default: ;
				endcase
			end
			ST_SWEEP: cmd.sweep_step = 1'b1;
			ST_PUT:   cmd.cur_op = CUR_PUT;
			ST_BS2:   cmd.blank_next = 1'b1;
			ST_DIV:   cmd.cur_op = stat.rem_ge_cols ? CUR_DIV_STEP : CUR_DIV_END;
			ST_DONE:  cmd.load_out = stat.out_free;
			default: ;
		endcase
	end

endmodule

@@ src/tcw_dpath.sv @@
// tcw_dpath: cursor registers, screen store sweep, row divider and result register
// depends on tcw_pkg and tcw_ram; commanded by tcw_ctrl
module tcw_dpath
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   item,
	input  logic [7:0] attr,
	input  ctl_cmd_t   cmd,
	output dp_stat_t   stat,
	output logic       result_valid,
	input  logic       result_stall,
	output out_item_t  result
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW    = $clog2(CELLS + 1);
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int KW    = $clog2(COLUMNS);

	logic [2:0]            op_q;
	logic [7:0]            char_q;
	logic [CELL_IDX_W-1:0] idx_q;

	logic [CW-1:0] cur_q;
	logic [RW-1:0] row_q;
	logic [KW-1:0] col_q;
	logic [CW-1:0] rem_q;

	logic [CW-1:0] ptr_q;
	sweep_mode_t   mode_q;
	logic          wr_pend_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          use_rd_s1;
	logic [15:0]   blank_s1;

	logic      scrolled_q;
	logic      read_hit_q;
	logic      out_valid_q;
	out_item_t out_q;

	logic          idx_hit;
	logic [CW-1:0] idx_sat;
	logic [CW-1:0] cur_dec;
	logic [CW-1:0] cur_inc;
	logic [CW-1:0] row_start;
	logic          sweep_rd;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	assign idx_hit   = 32'(idx_q) < CELLS;
	assign idx_sat   = (32'(idx_q) > CELLS) ? CW'(CELLS) : CW'(idx_q);
	assign cur_dec   = (cur_q != '0) ? (cur_q - CW'(1)) : '0;
	assign cur_inc   = cur_q + CW'(1);
	assign row_start = cur_q - CW'(col_q);
	assign sweep_rd  = cmd.sweep_step && (mode_q == SWP_SCROLL) && (ptr_q < CW'(CELLS - COLUMNS));

	assign stat.op          = op_q;
	assign stat.past_end    = cur_q == CW'(CELLS);
	assign stat.nl_scroll   = row_q >= RW'(ROWS - 1);
	assign stat.sweep_done  = ptr_q == CW'(CELLS);
	assign stat.rem_ge_cols = rem_q >= CW'(COLUMNS);
	assign stat.out_free    = !out_valid_q || !result_stall;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= item.op;
			char_q <= item.char_code;
			idx_q  <= item.cell_index;
		end
	end

	// cursor, kept both linear and as row and column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			row_q <= '0;
			col_q <= '0;
		end else begin
			case (cmd.cur_op)
				CUR_SCROLL_BACK: begin
					cur_q <= cur_q - CW'(COLUMNS);
					row_q <= row_q - RW'(1);
				end
				CUR_NEWLINE: begin
					col_q <= '0;
					if (row_q >= RW'(ROWS - 1)) begin
						cur_q <= row_start;
					end else begin
						cur_q <= row_start + CW'(COLUMNS);
						row_q <= row_q + RW'(1);
					end
				end
				CUR_PUT: begin
					if (char_q == NEWLINE_CODE) begin
						cur_q <= row_start + CW'(COLUMNS);
						row_q <= row_q + RW'(1);
						col_q <= '0;
					end else begin
						cur_q <= cur_inc;
						if (col_q == KW'(COLUMNS - 1)) begin
							col_q <= '0;
							row_q <= row_q + RW'(1);
						end else begin
							col_q <= col_q + KW'(1);
						end
					end
				end
				CUR_BACK: begin
					cur_q <= cur_dec;
					if (cur_q != '0) begin
						if (col_q == '0) begin
							col_q <= KW'(COLUMNS - 1);
							row_q <= row_q - RW'(1);
						end else begin
							col_q <= col_q - KW'(1);
						end
					end
				end
				CUR_ZERO: begin
					cur_q <= '0;
					row_q <= '0;
					col_q <= '0;
				end
				CUR_LOAD: begin
					cur_q <= idx_sat;
					row_q <= '0;
				end
				CUR_DIV_STEP: row_q <= row_q + RW'(1);
				CUR_DIV_END:  col_q <= KW'(rem_q);
				default: ;
			endcase
		end
	end

	// remainder of the repeated subtraction that splits a cell index into row and column
	always_ff @(posedge clk) begin
		if (cmd.cur_op == CUR_LOAD) begin
			rem_q <= idx_sat;
		end else if (cmd.cur_op == CUR_DIV_STEP) begin
			rem_q <= rem_q - CW'(COLUMNS);
		end
	end

	// sweep pointer over all cells for scroll, clear and the reset fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			mode_q     <= SWP_INIT;
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= 1'b0;
			if (cmd.sweep_start) begin
				ptr_q  <= '0;
				mode_q <= cmd.sweep_mode;
			end else if (cmd.sweep_step && (ptr_q != CW'(CELLS))) begin
				ptr_q      <= ptr_q + CW'(1);
				wr_pend_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= AW'(ptr_q);
		use_rd_s1  <= sweep_rd;
		blank_s1   <= (mode_q == SWP_INIT) ? {RESET_ATTR, BLANK_CODE} : {attr, BLANK_CODE};
	end

	// screen store ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(cur_q);
		ram_wdata = {attr, BLANK_CODE};
		if (wr_pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = use_rd_s1 ? ram_rdata : blank_s1;
		end else if ((cmd.cur_op == CUR_PUT) && (char_q != NEWLINE_CODE)) begin
			ram_we    = 1'b1;
			ram_wdata = {attr, char_q};
		end else if (cmd.cur_op == CUR_BACK) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(cur_dec);
		end else if (cmd.blank_next) begin
			ram_we    = cur_inc < CW'(CELLS);
			ram_waddr = AW'(cur_inc);
		end
	end

	assign ram_re    = sweep_rd || (cmd.rd_cell && idx_hit);
	assign ram_raddr = sweep_rd ? AW'(ptr_q + CW'(COLUMNS)) : AW'(idx_q);

	tcw_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_screen (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// per transaction flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scrolled_q <= 1'b0;
			read_hit_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				scrolled_q <= 1'b0;
				read_hit_q <= 1'b0;
			end else begin
				if (cmd.sweep_start && (cmd.sweep_mode == SWP_SCROLL)) scrolled_q <= 1'b1;
				if (cmd.rd_cell) read_hit_q <= idx_hit;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.cursor_cell <= CELL_IDX_W'(cur_q);
			out_q.cell_char   <= read_hit_q ? ram_rdata[7:0] : 8'h00;
			out_q.cell_attr   <= read_hit_q ? ram_rdata[15:8] : 8'h00;
			out_q.scrolled    <= scrolled_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ src/text_console_writer.sv @@
// text_console_writer: top level of the text console engine
// depends on tcw_pkg, tcw_ctrl, tcw_dpath (which holds tcw_ram)
//
// Character-cell console: a ROWS x COLUMNS screen store of character and
// attribute bytes plus a cursor. Each input transaction carries one operation
// (put char, newline, backspace, clear, set cursor, read cell) and yields
// exactly one result transaction with the cursor after the operation, the
// character and attribute of a read cell, and a flag if the screen scrolled.
// Backspace blanks two cells through the one write port; set cursor finds the
// target row by repeated subtraction of COLUMNS; clear and a put char or
// newline that scrolls sweep the store, one cell moved or blanked per cycle.
// After reset the block fills the store with blanks in attribute 15 and
// accepts no transaction meanwhile; configuration writes are taken
// throughout. A new transaction is accepted while the previous result is
// still waiting at the output. The attribute register sits at byte address 0.
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	// input transactions
	input  logic               item_valid,
	output logic               item_stall,
	input  in_item_t           item,
	// result transactions
	output logic               result_valid,
	input  logic               result_stall,
	output out_item_t          result,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [7:0] attr_q;
	ctl_cmd_t   cmd;
	dp_stat_t   stat;

	// attribute register, written in the access phase
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (psel && penable && pwrite && (paddr[2:2] == REG_TEXT_ATTR)) begin
			attr_q <= pwdata[7:0];
		end
	end

	always_comb begin
		unique case (paddr[2:2])
			REG_TEXT_ATTR: prdata = {{(PDATA_W - 8){1'b0}}, attr_q};
			default:       prdata = '0;
		endcase
	end

	// sequencer
	tcw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// cursor, screen store and result register
	tcw_dpath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.attr         (attr_q),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ src/tcw_checker.sv @@
// tcw_checker: port-level checks of the text console writer, bound to the top level
// depends on tcw_pkg
module tcw_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input in_item_t  item,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	localparam int CELLS = COLUMNS * ROWS;

	// a held result keeps its contents
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
	else $error("result changed while stalled");

	// an accepted transaction is always followed by a stall of the input
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
	else $error("transaction accepted in back to back cycles");

	// cursor never beyond the past-end position
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> 32'(result.cursor_cell) <= CELLS)
	else $error("cursor beyond screen");

	// after a scroll the cursor lies in the bottom row or just past it
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.scrolled |-> 32'(result.cursor_cell) >= (CELLS - COLUMNS))
	else $error("scrolled result with cursor above bottom row");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (.*);

@@ tb/sv/text_console_writer_test.sv @@
// text_console_writer_test: self-checking testbench for the text console engine
// holds a cycle-free predictor of the screen store, cursor and attribute register
// depends on tcw_pkg and the text_console_writer rtl only
module text_console_writer_test;
	import tcw_pkg::*;

	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int CELLS        = COLUMNS * ROWS;
	localparam int RANDOM_ITEMS = 600;
	localparam int CFG_EVERY    = 150;
	localparam int MAX_REPORTS  = 40;
	localparam int TIMEOUT      = 20_000_000;

	// op codes the block leaves unused
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	// attribute register lives at byte address 0
	localparam logic [PADDR_W-1:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	in_item_t           item;
	logic               result_valid;
	logic               result_stall;
	out_item_t          result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// shadow copy of the console state
	logic [15:0] shadow_screen [CELLS];
	int          shadow_cursor;
	logic [7:0]  shadow_attr;

	// results predicted for accepted transactions, oldest first
	out_item_t pending_results [$];

	int  error_count   = 0;
	int  checked_count = 0;
	int  items_sent    = 0;
	int  scroll_count  = 0;
	int  clear_count   = 0;
	int  attr_settings = 0;
	int  hold_request  = 0;
	bit  no_idle       = 0;

	text_console_writer uut (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void put_cell(int idx, logic [7:0] ch);
		// anything past the last cell is dropped
		if (idx < CELLS) begin
			shadow_screen[idx] = {shadow_attr, ch};
		end
	endfunction

	function automatic void scroll_screen();
		for (int i = 0; i < CELLS - COLUMNS; i++) begin
			shadow_screen[i] = shadow_screen[i + COLUMNS];
		end
		// bottom row blanked in the attribute in force now
		for (int c = 0; c < COLUMNS; c++) begin
			put_cell(CELLS - COLUMNS + c, BLANK_CODE);
		end
		scroll_count++;
	endfunction

	function automatic out_item_t console_step(in_item_t it);
		out_item_t r;
		int        nxt;
		r = '0;
		case (it.op)
			OP_PUT_CHAR: begin
				// cursor past the end scrolls before anything else
				if (shadow_cursor >= CELLS) begin
					scroll_screen();
					shadow_cursor -= COLUMNS;
					r.scrolled = 1'b1;
				end
				// an embedded newline never scrolls, it may leave the cursor past the end
				if (it.char_code == NEWLINE_CODE) begin
					shadow_cursor = (shadow_cursor / COLUMNS + 1) * COLUMNS;
				end else begin
					put_cell(shadow_cursor, it.char_code);
					shadow_cursor++;
				end
			end
			OP_NEWLINE: begin
				nxt = (shadow_cursor / COLUMNS + 1) * COLUMNS;
				if (nxt >= CELLS) begin
					scroll_screen();
					nxt -= COLUMNS;
					r.scrolled = 1'b1;
				end
				shadow_cursor = nxt;
			end
			OP_BACKSPACE: begin
				// clamps at cell 0, blanks the new cell and the one after it
				nxt = (shadow_cursor > 0) ? shadow_cursor - 1 : 0;
				put_cell(nxt, BLANK_CODE);
				put_cell(nxt + 1, BLANK_CODE);
				shadow_cursor = nxt;
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					put_cell(i, BLANK_CODE);
				end
				shadow_cursor = 0;
				clear_count++;
			end
			OP_SET_CUR: begin
				shadow_cursor = (it.cell_index > CELLS) ? CELLS : int'(it.cell_index);
			end
			OP_READ_CELL: begin
				if (it.cell_index < CELLS) begin
					r.cell_char = shadow_screen[it.cell_index][7:0];
					r.cell_attr = shadow_screen[it.cell_index][15:8];
				end
			end
			default: begin
				// unused codes leave everything alone
			end
		endcase
		r.cursor_cell = CELL_IDX_W'(shadow_cursor);
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	// one input transaction; returns at the edge that accepts it
	task automatic send_item(logic [2:0] op, logic [7:0] ch, logic [CELL_IDX_W-1:0] idx);
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 99) < 30) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		item.op         = op;
		item.char_code  = ch;
		item.cell_index = idx;
		item_valid      = 1'b1;
		do @(posedge clk); while (item_stall);
		// the prediction is taken at acceptance, so attribute writes are already seen
		pending_results.push_back(console_step(item));
		items_sent++;
	endtask

	// sender goes quiet until every predicted result has come back
	task automatic wait_for_results();
		@(negedge clk);
		item_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic read_attribute(output logic [7:0] value);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b0;
		penable = 1'b0;
		paddr   = ATTR_ADDR;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata[7:0];
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// only called while the block is idle
	task automatic write_attribute(logic [7:0] value);
		logic [7:0] readback;
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = ATTR_ADDR;
		pwdata  = {{(PDATA_W - 8){1'b0}}, value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		shadow_attr = value;
		attr_settings++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		read_attribute(readback);
		if (readback !== value) begin
			error_count++;
			$display("%0t attribute readback: expected %0h, actual %0h", $time, value, readback);
		end
	endtask

	// ---------------------------------------------------------------- receiver

	// random stalls, a quiet stretch, and long hold-offs on request
	initial begin
		int hold_left;
		hold_left    = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_stall = 1'b1;
				hold_left--;
			end else if (no_idle) begin
				result_stall = 1'b0;
			end else begin
				result_stall = ($urandom_range(0, 99) < 30);
			end
		end
	end

	// ---------------------------------------------------------------- checker

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			error_count++;
			if (error_count <= MAX_REPORTS) begin
				$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			end
		end
	endfunction

	out_item_t oldest_result;

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("%0t unexpected result transaction: expected none, actual %0h",
						$time, result);
				end
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("cursor_cell", int'(oldest_result.cursor_cell),
					int'(result.cursor_cell));
				check_field("cell_char", int'(oldest_result.cell_char), int'(result.cell_char));
				check_field("cell_attr", int'(oldest_result.cell_attr), int'(result.cell_attr));
				check_field("scrolled", int'(oldest_result.scrolled), int'(result.scrolled));
				checked_count++;
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// register reset value and the blank screen, reads at and past the end
	task automatic test_reset_state();
		logic [7:0] value;
		read_attribute(value);
		if (value !== RESET_ATTR) begin
			error_count++;
			$display("%0t attribute after reset: expected %0h, actual %0h",
				$time, RESET_ATTR, value);
		end
		send_item(OP_READ_CELL, 8'($urandom), 11'd0);
		send_item(OP_READ_CELL, 8'($urandom), 11'd1999);
		send_item(OP_READ_CELL, 8'($urandom), 11'd2000);
		send_item(OP_READ_CELL, 8'($urandom), 11'h7FF);
		wait_for_results();
	endtask

	// character extremes in the widest attribute
	task automatic test_put_char();
		write_attribute(8'hFF);
		send_item(OP_SET_CUR, 8'($urandom), 11'd0);
		send_item(OP_PUT_CHAR, 8'h41, CELL_IDX_W'($urandom));
		send_item(OP_PUT_CHAR, 8'h00, CELL_IDX_W'($urandom));
		send_item(OP_PUT_CHAR, 8'hFF, CELL_IDX_W'($urandom));
		send_item(OP_READ_CELL, 8'($urandom), 11'd0);
		send_item(OP_READ_CELL, 8'($urandom), 11'd1);
		send_item(OP_READ_CELL, 8'($urandom), 11'd2);
		wait_for_results();
	endtask

	// backspace clamp, saturating set cursor, scrolls from both kinds of op, unused codes
	task automatic test_cursor_edges();
		write_attribute(8'h00);
		send_item(OP_BACKSPACE, 8'($urandom), CELL_IDX_W'($urandom));
		send_item(OP_SET_CUR, 8'($urandom), 11'd0);
		send_item(OP_BACKSPACE, 8'($urandom), CELL_IDX_W'($urandom));
		send_item(OP_SET_CUR, 8'($urandom), 11'h7FF);
		// second blank would land past the last cell
		send_item(OP_BACKSPACE, 8'($urandom), CELL_IDX_W'($urandom));
		send_item(OP_SET_CUR, 8'($urandom), 11'd1995);
		send_item(OP_NEWLINE, 8'($urandom), CELL_IDX_W'($urandom));
		send_item(OP_SET_CUR, 8'($urandom), 11'd2000);
		send_item(OP_PUT_CHAR, 8'h78, CELL_IDX_W'($urandom));
		send_item(OP_SET_CUR, 8'($urandom), 11'd2000);
		// scrolls first, then the newline leaves the cursor past the end again
		send_item(OP_PUT_CHAR, NEWLINE_CODE, CELL_IDX_W'($urandom));
		send_item(OP_SPARE_A, 8'($urandom), CELL_IDX_W'($urandom));
		send_item(OP_SPARE_B, 8'($urandom), CELL_IDX_W'($urandom));
		wait_for_results();
	endtask

	task automatic test_clear_screen();
		write_attribute(8'hA5);
		send_item(OP_CLEAR, 8'($urandom), CELL_IDX_W'($urandom));
		send_item(OP_READ_CELL, 8'($urandom), 11'd1999);
		wait_for_results();
	endtask

	// receiver holds off long enough for the block to fill and stall its input
	task automatic test_output_backpressure();
		hold_request = 300;
		send_item(OP_SET_CUR, 8'($urandom), 11'd800);
		repeat (16) send_item(OP_PUT_CHAR, 8'($urandom_range(33, 126)), CELL_IDX_W'($urandom));
		send_item(OP_READ_CELL, 8'($urandom), 11'd805);
		wait_for_results();
	endtask

	// mostly well-formed typing with random content, plus noise
	task automatic test_random_traffic();
		int         first_item;
		int         next_cfg;
		int         cfg_round;
		int         kind;
		int         pick;
		int         len;
		logic [7:0] attr;
		first_item = items_sent;
		next_cfg   = CFG_EVERY;
		cfg_round  = 0;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			// attribute changes between phases, extremes among them
			if (items_sent - first_item >= next_cfg) begin
				wait_for_results();
				case (cfg_round % 3)
					0:       attr = 8'h00;
					1:       attr = 8'hFF;
					default: attr = 8'($urandom_range(0, 255));
				endcase
				write_attribute(attr);
				cfg_round++;
				next_cfg += CFG_EVERY;
			end
			// one stretch with no idling on either side
			no_idle = (items_sent - first_item >= 250) && (items_sent - first_item < 350);
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				// typing burst, a quarter of them on the bottom row so they scroll
				if ($urandom_range(0, 3) == 0) begin
					send_item(OP_SET_CUR, 8'($urandom),
						CELL_IDX_W'($urandom_range(CELLS - COLUMNS, CELLS)));
				end else begin
					send_item(OP_SET_CUR, 8'($urandom),
						CELL_IDX_W'($urandom_range(0, CELLS - 1)));
				end
				len = $urandom_range(4, 12);
				repeat (len) begin
					pick = $urandom_range(0, 99);
					if (pick < 60) begin
						send_item(OP_PUT_CHAR, 8'($urandom_range(0, 255)),
							CELL_IDX_W'($urandom));
					end else if (pick < 70) begin
						send_item(OP_PUT_CHAR, NEWLINE_CODE, CELL_IDX_W'($urandom));
					end else if (pick < 80) begin
						send_item(OP_NEWLINE, 8'($urandom), CELL_IDX_W'($urandom));
					end else if (pick < 90) begin
						send_item(OP_BACKSPACE, 8'($urandom), CELL_IDX_W'($urandom));
					end else begin
						// look back at the cell just typed
						send_item(OP_READ_CELL, 8'($urandom),
							CELL_IDX_W'((shadow_cursor > 0) ? shadow_cursor - 1 : 0));
					end
				end
			end else if (kind < 70) begin
				// reads, a few of them at or past the end
				len = $urandom_range(3, 8);
				repeat (len) begin
					if ($urandom_range(0, 9) == 0) begin
						send_item(OP_READ_CELL, 8'($urandom),
							CELL_IDX_W'($urandom_range(CELLS, 2047)));
					end else begin
						send_item(OP_READ_CELL, 8'($urandom),
							CELL_IDX_W'($urandom_range(0, CELLS - 1)));
					end
				end
			end else if (kind < 85) begin
				// noise: any op code, any field values
				len = $urandom_range(1, 4);
				repeat (len) begin
					send_item(3'($urandom_range(0, 7)), 8'($urandom),
						CELL_IDX_W'($urandom_range(0, 2047)));
				end
			end else begin
				// newlines off the bottom, then check the rows that moved up
				send_item(OP_SET_CUR, 8'($urandom),
					CELL_IDX_W'($urandom_range(CELLS - COLUMNS, CELLS)));
				len = $urandom_range(1, 3);
				repeat (len) send_item(OP_NEWLINE, 8'($urandom), CELL_IDX_W'($urandom));
				repeat (2) begin
					send_item(OP_READ_CELL, 8'($urandom),
						CELL_IDX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1)));
				end
			end
		end
		no_idle = 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		// shadow state matches the store after its clearing pass
		for (int i = 0; i < CELLS; i++) begin
			shadow_screen[i] = {RESET_ATTR, BLANK_CODE};
		end
		shadow_cursor = 0;
		shadow_attr   = RESET_ATTR;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_put_char();
		test_cursor_edges();
		test_clear_screen();
		test_output_backpressure();
		test_random_traffic();

		wait_for_results();
		// any stray result would show up during this wait
		repeat (16) @(posedge clk);

		$display("run covered %0d transactions, %0d scrolls and %0d clears",
			checked_count, scroll_count, clear_count);
		$display("attribute register written %0d times, %0d mismatches",
			attr_settings, error_count);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// hang guard
	initial begin
		#(TIMEOUT);
		$display("tb: failure");
		$finish;
	end

endmodule
